/* sv/mbps_pkg.sv */
// Package: shared constants, types and helpers of the masked byte pattern scanner.
`timescale 1ns / 1ps

package mbps_pkg;

  // Sizes of the pattern store, offset counter and register fields
  localparam int PATTERN_MAX = 32;
  localparam int OFFSET_BITS = 32;
  localparam int MASK_W      = 32;
  localparam int ADDR_W      = 64;
  localparam int OFS_OUT_W   = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int LEN_REG_W   = 6;
  localparam int BYTES_PER_WORD = CFG_DATA_W / 8;
  localparam int LEN_W       = $clog2(PATTERN_MAX);

  typedef logic [7:0]                    byte_t;
  typedef logic [LEN_W-1:0]              len_t;
  typedef logic [PATTERN_MAX-1:0][7:0]   pat_bytes_t;
  typedef logic [PATTERN_MAX-2:0][7:0]   hist_t;
  typedef logic [OFFSET_BITS-1:0]        count_t;

  localparam count_t COUNT_MAX = {OFFSET_BITS{1'b1}};

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO     = 3'd0,
    CFG_PAT_MID_LO = 3'd1,
    CFG_PAT_MID_HI = 3'd2,
    CFG_PAT_HI     = 3'd3,
    CFG_EXACT_MASK = 3'd4,
    CFG_PAT_LEN    = 3'd5,
    CFG_FIND_ALL   = 3'd6,
    CFG_BASE       = 3'd7
  } cfg_reg_e;

  // Pattern settings handed to the window compare
  typedef struct packed {
    pat_bytes_t        pat;
    logic [MASK_W-1:0] mask;
    len_t              len_m1;
  } pat_cfg_t;

  // Map the length register to length minus one; zero acts as one, large values clamp
  function automatic len_t eff_len_m1(input logic [LEN_REG_W-1:0] len);
    len_t r;
    if (len == '0) begin
      r = '0;
    end else if (len > LEN_REG_W'(PATTERN_MAX)) begin
      r = len_t'(PATTERN_MAX - 1);
    end else begin
      r = len_t'(len - LEN_REG_W'(1));
    end
    return r;
  endfunction

endpackage

/* sv/mbps_byte_if.sv */
// Interface: byte stream channel into the scanner.
`timescale 1ns / 1ps

interface mbps_byte_if;
  logic            valid;
  logic            ready;
  mbps_pkg::byte_t data_byte;
  logic            region_last;

  modport source (output valid, output data_byte, output region_last, input ready);
  modport sink   (input valid, input data_byte, input region_last, output ready);
endinterface

/* sv/mbps_result_if.sv */
// Interface: result channel out of the scanner.
`timescale 1ns / 1ps

interface mbps_result_if;
  logic                                valid;
  logic                                ready;
  logic                                match_found;
  logic [mbps_pkg::OFS_OUT_W-1:0]      match_offset;
  logic [mbps_pkg::ADDR_W-1:0]         match_address;
  logic                                region_done;
  logic                                offset_overflow;

  modport source (output valid, output match_found, output match_offset,
                  output match_address, output region_done, output offset_overflow,
                  input ready);
  modport sink   (input valid, input match_found, input match_offset,
                  input match_address, input region_done, input offset_overflow,
                  output ready);
endinterface

/* sv/mbps_match.sv */
// Window compare: all pattern positions checked in parallel against the byte window.
`timescale 1ns / 1ps

module mbps_match (
  input  mbps_pkg::byte_t    cur,
  input  mbps_pkg::hist_t    hist,
  input  mbps_pkg::pat_cfg_t cfg,
  output logic               hit
);

  logic [mbps_pkg::PATTERN_MAX-1:0][7:0] win;
  logic [mbps_pkg::PATTERN_MAX-1:0]      pos_ok;
  logic [mbps_pkg::PATTERN_MAX-1:0]      exact;

  // Build the window: entry 0 is the current byte, then newest history first
  always_comb begin
    win[0] = cur;
    for (int i = 1; i < mbps_pkg::PATTERN_MAX; i++) begin
      win[i] = hist[i-1];
    end
  end

  // Pattern bytes past the mask register are wildcards
  always_comb begin
    for (int j = 0; j < mbps_pkg::PATTERN_MAX; j++) begin
      exact[j] = (j < mbps_pkg::MASK_W) ? cfg.mask[j % mbps_pkg::MASK_W] : 1'b0;
    end
  end

  // Pattern byte j lines up with the window byte len-1-j back from the current one
  always_comb begin
    for (int j = 0; j < mbps_pkg::PATTERN_MAX; j++) begin
      pos_ok[j] = 1'b1;
      if ((mbps_pkg::LEN_W'(j) <= cfg.len_m1) && exact[j]) begin
        pos_ok[j] = (win[cfg.len_m1 - mbps_pkg::LEN_W'(j)] == cfg.pat[j]);
      end
    end
  end

  assign hit = &pos_ok;

endmodule

/* sv/masked_byte_pattern_scanner.sv */
// An accepted item is held in the input stage register, its result in the result register.
// Throughput: one byte per cycle while the result register is free; set by the parallel
// compare of all pattern positions against a shift window, then one 64-bit address add.
// Items that cause no result (no reported match, not the last byte) produce no output.
// Reset (rst, synchronous, active high) clears control state and the registers to their
// defaults; the byte history is not cleared, windows are gated by the per-region byte count.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
  mbps_byte_if.sink                           scan_in,
  mbps_result_if.source                       scan_out
);

  // Configuration registers
  mbps_pkg::pat_bytes_t                 pat;
  logic [mbps_pkg::MASK_W-1:0]          exact_mask;
  logic [mbps_pkg::LEN_REG_W-1:0]       pattern_length;
  logic                                 find_all;
  logic [mbps_pkg::ADDR_W-1:0]          region_base;

  // Scan state
  mbps_pkg::hist_t                      hist;
  mbps_pkg::count_t                     bytes_seen;
  mbps_pkg::count_t                     bytes_seen_next;
  logic                                 first_taken;
  logic                                 first_taken_next;
  logic                                 saturated;
  logic                                 saturated_next;

  // Input stage
  logic                                 s1_valid;
  mbps_pkg::byte_t                      s1_byte;
  logic                                 s1_last;

  // Result stage
  logic                                 out_valid;
  logic                                 out_found;
  logic [mbps_pkg::OFS_OUT_W-1:0]       out_offset;
  logic [mbps_pkg::ADDR_W-1:0]          out_address;
  logic                                 out_done;
  logic                                 out_ovf;

  // Datapath
  mbps_pkg::pat_cfg_t                   pcfg;
  logic                                 hit;
  logic                                 report;
  logic                                 produce;
  logic                                 advance;
  logic                                 out_free;
  mbps_pkg::count_t                     offset;
  logic [mbps_pkg::ADDR_W-1:0]          address;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pat            <= '0;
      exact_mask     <= '0;
      pattern_length <= mbps_pkg::LEN_REG_W'(1);
      find_all       <= 1'b0;
      region_base    <= '0;
    end else if (cfg_we) begin
      unique case (mbps_pkg::cfg_reg_e'(cfg_index))
        mbps_pkg::CFG_PAT_LO, mbps_pkg::CFG_PAT_MID_LO,
        mbps_pkg::CFG_PAT_MID_HI, mbps_pkg::CFG_PAT_HI: begin
          for (int k = 0; k < mbps_pkg::BYTES_PER_WORD; k++) begin
            if (int'(cfg_index) * mbps_pkg::BYTES_PER_WORD + k < mbps_pkg::PATTERN_MAX) begin
              pat[mbps_pkg::LEN_W'(int'(cfg_index) * mbps_pkg::BYTES_PER_WORD + k)]
                <= cfg_data[8*k +: 8];
            end
          end
        end
        mbps_pkg::CFG_EXACT_MASK: exact_mask     <= cfg_data[mbps_pkg::MASK_W-1:0];
        mbps_pkg::CFG_PAT_LEN:    pattern_length <= cfg_data[mbps_pkg::LEN_REG_W-1:0];
        mbps_pkg::CFG_FIND_ALL:   find_all       <= cfg_data[0];
        mbps_pkg::CFG_BASE:       region_base    <= cfg_data[mbps_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pcfg.pat    = pat;
  assign pcfg.mask   = exact_mask;
  assign pcfg.len_m1 = mbps_pkg::eff_len_m1(pattern_length);

  mbps_match u_match (
    .cur  (s1_byte),
    .hist (hist),
    .cfg  (pcfg),
    .hit  (hit)
  );

  // Handshake: the input stage moves on whenever the result register is free
  assign out_free      = !out_valid || scan_out.ready;
  assign advance       = s1_valid && out_free;
  assign scan_in.ready = !s1_valid || out_free;

  // Decide the report and compute offset and address
  assign report  = (bytes_seen >= mbps_pkg::OFFSET_BITS'(pcfg.len_m1)) && hit
                   && (find_all || !first_taken);
  assign produce = report || s1_last;
  assign offset  = bytes_seen - mbps_pkg::OFFSET_BITS'(pcfg.len_m1);
  assign address = region_base + mbps_pkg::ADDR_W'(offset);

  // Next region state: advance the count, pin it at the top, clear at region end
  always_comb begin
    first_taken_next = first_taken || report;
    if (bytes_seen == mbps_pkg::COUNT_MAX) begin
      bytes_seen_next = bytes_seen;
      saturated_next  = 1'b1;
    end else begin
      bytes_seen_next = bytes_seen + mbps_pkg::OFFSET_BITS'(1);
      saturated_next  = saturated;
    end
    if (s1_last) begin
      bytes_seen_next  = '0;
      first_taken_next = 1'b0;
      saturated_next   = 1'b0;
    end
  end

  // Hold the input item until it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan_in.ready) begin
      s1_valid <= scan_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_in.valid && scan_in.ready) begin
      s1_byte <= scan_in.data_byte;
      s1_last <= scan_in.region_last;
    end
  end

  // Update region state as an item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen  <= '0;
      first_taken <= 1'b0;
      saturated   <= 1'b0;
    end else if (advance) begin
      bytes_seen  <= bytes_seen_next;
      first_taken <= first_taken_next;
      saturated   <= saturated_next;
    end
  end

  // Shift the byte history, newest at entry 0
  always_ff @(posedge clk) begin
    if (advance) begin
      hist <= {hist[mbps_pkg::PATTERN_MAX-3:0], s1_byte};
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (scan_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      out_found   <= report;
      out_offset  <= report ? mbps_pkg::OFS_OUT_W'(offset) : '0;
      out_address <= report ? address : '0;
      out_done    <= s1_last;
      out_ovf     <= saturated;
    end
  end

  assign scan_out.valid           = out_valid;
  assign scan_out.match_found     = out_found;
  assign scan_out.match_offset    = out_offset;
  assign scan_out.match_address   = out_address;
  assign scan_out.region_done     = out_done;
  assign scan_out.offset_overflow = out_ovf;

  // A result exists only for a reported match or a region end
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_found || out_done))
    else $error("result without match or region end");

  // A result without a match carries zero offset and address
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_offset == '0 && out_address == '0))
    else $error("non-match result carries offset or address");

  // Region end resets the count and the overflow flag
  a_region_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> (bytes_seen == '0 && !saturated && !first_taken))
    else $error("region state not cleared after last byte");

  // The overflow flag is set only with the count pinned at its top
  a_sat_pinned: assert property (@(posedge clk) disable iff (rst)
    saturated |-> (bytes_seen == mbps_pkg::COUNT_MAX))
    else $error("overflow flag set with count below top");

endmodule
